// ===== design/beacon_synced_drive_window_macros.svh =====
// Assertion macros shared by the beacon drive window design.
`ifndef BEACON_SYNCED_DRIVE_WINDOW_MACROS_SVH
`define BEACON_SYNCED_DRIVE_WINDOW_MACROS_SVH

// Same-cycle implication, clocked on i_clk and disabled during reset.
`define BSDW_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsdw: same-cycle check failed");

// Next-cycle implication, clocked on i_clk and disabled during reset.
`define BSDW_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsdw: next-cycle check failed");

`endif

// ===== design/bsdw_pkg.sv =====
// Shared types and constants of the beacon drive window design.
`default_nettype none

package bsdw_pkg;

    localparam int WINDOW_SAMPLES_DEF = 8;
    localparam int TIME_W = 32;
    localparam int RPM_W = 16;
    localparam int CFG_W = 9;
    localparam int PROD_W = CFG_W + TIME_W;
    localparam int HALF_SHIFT = 9;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_FIELDS_W = 3 + RPM_W;
    localparam int OUT_TDATA_W = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;
    localparam int DIV_CNT_W = 5;

    localparam logic [RPM_W-1:0] RPM_MAX = 16'd60000;
    localparam logic [TIME_W-1:0] ANGLE_DIV = 32'd360;

    // Division by 360 is a shift by 3 followed by a reciprocal multiply for 45.
    localparam int ANG_PRE_SHIFT = 3;
    localparam int RCP_W = 30;
    localparam int RCP_SHIFT = 35;
    localparam logic [RCP_W-1:0] RCP_45 = 30'd763549742;
    localparam int RCP_PROD_W = (TIME_W - ANG_PRE_SHIFT) + RCP_W;
    localparam int QUO_W = RCP_PROD_W - RCP_SHIFT;
    localparam int REM_W = 9;
    localparam int PART_W = CFG_W + REM_W;
    localparam int SRCP_W = 16;
    localparam int SRCP_SHIFT = 21;
    localparam logic [SRCP_W-1:0] SRCP_45 = 16'd46604;
    localparam int SRCP_PROD_W = (PART_W - ANG_PRE_SHIFT) + SRCP_W;
    localparam int PART_Q_W = SRCP_PROD_W - SRCP_SHIFT;

    localparam logic CFG_IDX_ANGLE = 1'b0;
    localparam logic CFG_IDX_FRAC = 1'b1;

    localparam logic [1:0] EVT_NONE = 2'd0;
    localparam logic [1:0] EVT_RISE = 2'd1;
    localparam logic [1:0] EVT_FALL = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic cur;
        logic [TIME_W-1:0] now;
    } t_evt;

    typedef struct packed {
        logic [CFG_W-1:0] angle;
        logic [CFG_W-1:0] frac;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/bsdw_front.sv =====
// Front end: debounces the beacon pin and classifies each sample's edge.
`default_nettype none

module bsdw_front #(
    parameter int WINDOW_SAMPLES = bsdw_pkg::WINDOW_SAMPLES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // ir_pin_level [0], now_ms [32:1], zero fill above
    input  wire logic [bsdw_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic i_q_full,
    output logic o_push,
    output bsdw_pkg::t_evt o_evt
);

    localparam int POS_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_SAMPLES - 1);

    logic [WINDOW_SAMPLES-1:0] r_ring;
    logic [WINDOW_SAMPLES-1:0] n_ring;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic r_flag;
    logic n_flag;
    logic w_level;
    logic w_flip;
    logic w_accept;

    assign w_level = ~i_s_axis_tdata[0];
    assign o_s_axis_tready = ~i_q_full;
    assign w_accept = i_s_axis_tvalid & ~i_q_full;

    always_comb begin
        n_ring = r_ring;
        n_ring[r_pos] = w_level;
    end

    assign w_flip = r_flag ? ~(|n_ring) : (&n_ring);
    assign n_flag = r_flag ^ w_flip;
    assign n_pos = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= '0;
            r_pos <= '0;
            r_flag <= 1'b0;
        end else if (w_accept) begin
            r_ring <= n_ring;
            r_pos <= n_pos;
            r_flag <= n_flag;
        end
    end

    assign o_push = w_accept;

    always_comb begin
        o_evt.cur = n_flag;
        o_evt.now = i_s_axis_tdata[bsdw_pkg::TIME_W:1];
        if (!w_flip) begin
            o_evt.kind = bsdw_pkg::EVT_NONE;
        end else if (n_flag) begin
            o_evt.kind = bsdw_pkg::EVT_RISE;
        end else begin
            o_evt.kind = bsdw_pkg::EVT_FALL;
        end
    end

endmodule

`default_nettype wire

// ===== design/bsdw_queue.sv =====
// Two-entry event queue between the front end and the back end.
`default_nettype none

module bsdw_queue (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire bsdw_pkg::t_evt i_evt,
    input  wire logic i_pop,
    output logic o_full,
    output logic o_empty,
    output bsdw_pkg::t_evt o_head
);

    bsdw_pkg::t_evt r_mem [0:bsdw_pkg::QUEUE_DEPTH-1];
    logic [bsdw_pkg::QPTR_W-1:0] r_wr;
    logic [bsdw_pkg::QPTR_W-1:0] r_rd;
    logic [bsdw_pkg::QCNT_W-1:0] r_cnt;
    logic w_push;
    logic w_pop;

    assign o_full = (r_cnt == bsdw_pkg::QCNT_W'(bsdw_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push = i_push & ~o_full;
    assign w_pop = i_pop & ~o_empty;
    assign o_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/bsdw_back.sv =====
// Back end: period, RPM and drive window arithmetic, window test and result register.
`default_nettype none

module bsdw_back (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire bsdw_pkg::t_cfg i_cfg,
    input  wire logic i_q_empty,
    input  wire bsdw_pkg::t_evt i_q_head,
    output logic o_q_pop,
    output logic o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // drive_now [0], beacon_seen [1], led_green [2], rpm [18:3], zero fill above
    output logic [bsdw_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int TW = bsdw_pkg::TIME_W;
    localparam int PW = bsdw_pkg::PROD_W;
    localparam int CW = bsdw_pkg::DIV_CNT_W;
    localparam int RW = bsdw_pkg::RPM_W;
    localparam int QW = bsdw_pkg::QUO_W;
    localparam int MW = bsdw_pkg::REM_W;
    localparam int AW = bsdw_pkg::PART_W;
    localparam int FW = bsdw_pkg::PART_Q_W;
    localparam int QPW = bsdw_pkg::RCP_PROD_W;
    localparam int FPW = bsdw_pkg::SRCP_PROD_W;
    localparam int SH = bsdw_pkg::ANG_PRE_SHIFT;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL = 4'd1;
    localparam logic [3:0] S_DIV = 4'd2;
    localparam logic [3:0] S_REM = 4'd3;
    localparam logic [3:0] S_PART = 4'd4;
    localparam logic [3:0] S_FQ = 4'd5;
    localparam logic [3:0] S_CENTRE = 4'd6;
    localparam logic [3:0] S_BOUND = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    logic [TW-1:0] r_now;
    logic r_cur;
    logic [TW-1:0] r_last;
    logic [TW-1:0] r_seen;
    logic r_sel;
    logic [TW-1:0] r_bnd [0:3];
    logic [RW-1:0] r_rpm;
    logic r_led;
    logic r_out_valid;
    logic [bsdw_pkg::OUT_FIELDS_W-1:0] r_out_data;

    logic [TW-1:0] r_period;
    logic [TW-1:0] r_half;
    logic [RW-1:0] r_dq;
    logic [TW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_q;
    logic [MW-1:0] r_pmod;
    logic [TW-1:0] r_aq;
    logic [AW-1:0] r_ar;
    logic [FW-1:0] r_fq;
    logic [TW-1:0] r_centre;

    logic [PW-1:0] w_prod_frac;
    logic [QPW-1:0] w_q_prod;
    logic [TW-1:0] w_pmod;
    logic [FPW-1:0] w_fq_prod;
    logic [TW:0] w_trial;
    logic [TW+1:0] w_diff;
    logic w_ge;
    logic w_out_free;
    logic w_drive;
    logic w_take;
    logic w_load;

    assign w_prod_frac = PW'(i_cfg.frac) * PW'(r_period);
    assign w_q_prod = QPW'(r_period[TW-1:SH]) * QPW'(bsdw_pkg::RCP_45);
    assign w_pmod = r_period - TW'(r_q) * bsdw_pkg::ANGLE_DIV;
    assign w_fq_prod = FPW'(r_ar[AW-1:SH]) * FPW'(bsdw_pkg::SRCP_45);

    assign w_trial = {r_rem, r_dq[RW-1]};
    assign w_diff = {1'b0, w_trial} - {2'b00, r_period};
    assign w_ge = ~w_diff[TW+1];

    assign w_out_free = ~r_out_valid | i_m_axis_tready;
    assign w_take = (r_state == S_IDLE) & ~i_q_empty;
    assign w_load = (r_state == S_OUT) & w_out_free;
    assign o_q_pop = w_take;

    assign w_drive = (i_cfg.frac != '0) &&
                     (((r_now > r_bnd[0]) && (r_now < r_bnd[1])) ||
                      ((r_now > r_bnd[2]) && (r_now < r_bnd[3])));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_head.kind == bsdw_pkg::EVT_RISE) ? S_MUL : S_OUT;
                end
            end
            S_MUL: n_state = (r_period == '0) ? S_REM : S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_REM;
                end
            end
            S_REM: n_state = S_PART;
            S_PART: n_state = S_FQ;
            S_FQ: n_state = S_CENTRE;
            S_CENTRE: n_state = S_BOUND;
            S_BOUND: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last <= '0;
            r_seen <= '0;
            r_sel <= 1'b0;
            r_bnd[0] <= '0;
            r_bnd[1] <= '0;
            r_bnd[2] <= '0;
            r_bnd[3] <= '0;
            r_rpm <= '0;
            r_led <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                if (i_q_head.kind == bsdw_pkg::EVT_RISE) begin
                    r_last <= i_q_head.now;
                    r_led <= 1'b1;
                end else if (i_q_head.kind == bsdw_pkg::EVT_FALL) begin
                    r_seen <= i_q_head.now - r_last;
                    r_led <= 1'b0;
                end
            end
            if (r_state == S_MUL && r_period == '0) begin
                r_rpm <= bsdw_pkg::RPM_MAX;
            end
            if (r_state == S_DIV && r_cnt == '0) begin
                r_rpm <= r_dq;
            end
            if (r_state == S_BOUND) begin
                if (r_sel) begin
                    r_bnd[0] <= r_centre - r_half;
                    r_bnd[1] <= r_centre + r_half;
                end else begin
                    r_bnd[2] <= r_centre - r_half;
                    r_bnd[3] <= r_centre + r_half;
                end
                r_sel <= ~r_sel;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_now <= i_q_head.now;
            r_cur <= i_q_head.cur;
            r_period <= i_q_head.now - r_last;
        end
        case (r_state)
            S_MUL: begin
                r_q <= w_q_prod[QPW-1:bsdw_pkg::RCP_SHIFT];
                r_half <= w_prod_frac[PW-1:bsdw_pkg::HALF_SHIFT];
                r_rem <= '0;
                r_dq <= bsdw_pkg::RPM_MAX;
                r_cnt <= CW'(RW);
            end
            S_DIV: begin
                if (r_cnt != '0) begin
                    r_rem <= w_ge ? w_diff[TW-1:0] : w_trial[TW-1:0];
                    r_dq <= {r_dq[RW-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            S_REM: begin
                r_pmod <= w_pmod[MW-1:0];
                r_aq <= TW'(i_cfg.angle) * TW'(r_q);
            end
            S_PART: begin
                r_ar <= AW'(i_cfg.angle) * AW'(r_pmod);
            end
            S_FQ: begin
                r_fq <= w_fq_prod[FPW-1:bsdw_pkg::SRCP_SHIFT];
            end
            S_CENTRE: begin
                r_centre <= r_now + (r_seen >> 1) + r_aq + TW'(r_fq);
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out_data <= {r_rpm, r_led, r_cur, w_drive};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = bsdw_pkg::OUT_TDATA_W'(r_out_data);

endmodule

`default_nettype wire

// ===== design/beacon_synced_drive_window.sv =====
// Top level of the beacon drive window block: configuration, front end, queue, back end.
`default_nettype none
`include "beacon_synced_drive_window_macros.svh"

// Each input item is one sample of the beacon pin with its millisecond time, and each
// yields exactly one result item. The front end debounces the pin over WINDOW_SAMPLES
// samples and hands the sample to a two-entry queue, so input is taken while the back
// end works. A sample without a beacon rising edge goes from idle to the result register.
// A rising edge divides the RPM one quotient bit per cycle, 16 steps and one to finish,
// then finds the drive heading share of the period by reciprocal multiplication in the
// MUL, REM, PART and FQ states, then window placement and the result register; a zero
// period skips the RPM division. The user must write configuration only while the block
// is idle; the block itself does not enforce this.
module beacon_synced_drive_window #(
    parameter int WINDOW_SAMPLES = bsdw_pkg::WINDOW_SAMPLES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // ir_pin_level [0], now_ms [32:1], zero fill above
    input  wire logic [bsdw_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // drive_now [0], beacon_seen [1], led_green [2], rpm [18:3], zero fill above
    output logic [bsdw_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_idx,
    input  wire logic [bsdw_pkg::CFG_W-1:0] i_cfg_wdata
);

    logic [bsdw_pkg::CFG_W-1:0] r_cfg_angle;
    logic [bsdw_pkg::CFG_W-1:0] r_cfg_frac;
    bsdw_pkg::t_cfg w_cfg;
    bsdw_pkg::t_evt w_evt;
    bsdw_pkg::t_evt w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_angle <= '0;
            r_cfg_frac <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsdw_pkg::CFG_IDX_ANGLE: r_cfg_angle <= i_cfg_wdata;
                bsdw_pkg::CFG_IDX_FRAC: r_cfg_frac <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.angle = r_cfg_angle;
    assign w_cfg.frac = r_cfg_frac;

    bsdw_front #(
        .WINDOW_SAMPLES(WINDOW_SAMPLES)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_q_full(w_full),
        .o_push(w_push),
        .o_evt(w_evt)
    );

    bsdw_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_evt(w_evt),
        .i_pop(w_pop),
        .o_full(w_full),
        .o_empty(w_empty),
        .o_head(w_head)
    );

    bsdw_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(w_cfg),
        .i_q_empty(w_empty),
        .i_q_head(w_head),
        .o_q_pop(w_pop),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    `BSDW_ASSERT_IMP(a_rpm_range, o_m_axis_tvalid, o_m_axis_tdata[18:3] <= bsdw_pkg::RPM_MAX)
    `BSDW_ASSERT_IMP(a_drive_needs_frac, o_m_axis_tvalid && o_m_axis_tdata[0], r_cfg_frac != '0)
    `BSDW_ASSERT_IMP(a_led_tracks_flag, o_m_axis_tvalid, o_m_axis_tdata[2] == o_m_axis_tdata[1])
    `BSDW_ASSERT_NEXT(a_queue_holds_full, w_full && !w_pop, w_full)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of beacon_synced_drive_window: directed edge cases, then random beacon sweeps.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = bsdw_pkg::TIME_W;
    localparam int RW = bsdw_pkg::RPM_W;
    localparam int CW = bsdw_pkg::CFG_W;
    localparam int NS = bsdw_pkg::WINDOW_SAMPLES_DEF;

    typedef struct packed {
        logic [RW-1:0] rpm;
        logic led_green;
        logic beacon_seen;
        logic drive_now;
    } t_beacon_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [bsdw_pkg::IN_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [bsdw_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = bsdw_pkg::CFG_IDX_ANGLE;
    logic [CW-1:0] i_cfg_wdata = '0;

    beacon_synced_drive_window uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the block's state.
    logic [CW-1:0] angle_setting = '0;
    logic [CW-1:0] frac_setting = '0;
    logic [NS-1:0] lit_history = '0;
    int history_pos = 0;
    logic beacon_flag = 1'b0;
    logic prev_beacon_flag = 1'b0;
    logic [TW-1:0] last_pulse_ms = '0;
    logic [TW-1:0] lit_duration_ms = '0;
    logic set_toggle = 1'b0;
    logic [TW-1:0] window_edges [4] = '{default: '0};
    logic [RW-1:0] rpm_shadow = '0;
    logic led_shadow = 1'b0;

    t_beacon_report drive_reports [$];
    logic [TW-1:0] clock_ms = '0;
    int burst_left = 0;
    int samples_sent = 0;
    int rising_edges = 0;
    int falling_edges = 0;
    int drive_hits = 0;
    int mismatches = 0;
    int ready_run = 0;
    logic ready_choppy = 1'b0;

    function automatic t_beacon_report beacon_drive_response(input logic pin,
                                                             input logic [TW-1:0] now);
        t_beacon_report rep;
        logic [TW-1:0] period;
        logic [TW-1:0] centre;
        logic [TW-1:0] half;
        logic [TW-1:0] quot;
        logic [63:0] prod;
        lit_history[history_pos] = ~pin;
        history_pos = (history_pos + 1) % NS;
        if (beacon_flag ? (lit_history == '0) : (&lit_history))
            beacon_flag = ~beacon_flag;
        if (beacon_flag != prev_beacon_flag) begin
            if (beacon_flag) begin
                led_shadow = 1'b1;
                rising_edges++;
                period = now - last_pulse_ms;
                quot = (period == '0) ? TW'(bsdw_pkg::RPM_MAX) :
                                        TW'(bsdw_pkg::RPM_MAX) / period;
                rpm_shadow = quot[RW-1:0];
                last_pulse_ms = now;
                prod = (64'(angle_setting) * 64'(period)) / 64'(bsdw_pkg::ANGLE_DIV);
                centre = now + (lit_duration_ms >> 1) + prod[TW-1:0];
                prod = (64'(frac_setting) * 64'(period)) >> bsdw_pkg::HALF_SHIFT;
                half = prod[TW-1:0];
                if (set_toggle) begin
                    window_edges[0] = centre - half;
                    window_edges[1] = centre + half;
                end else begin
                    window_edges[2] = centre - half;
                    window_edges[3] = centre + half;
                end
                set_toggle = ~set_toggle;
            end else begin
                led_shadow = 1'b0;
                falling_edges++;
                lit_duration_ms = now - last_pulse_ms;
            end
        end
        prev_beacon_flag = beacon_flag;
        rep.drive_now = (frac_setting != '0) &&
                        ((now > window_edges[0] && now < window_edges[1]) ||
                         (now > window_edges[2] && now < window_edges[3]));
        rep.beacon_seen = beacon_flag;
        rep.led_green = led_shadow;
        rep.rpm = rpm_shadow;
        return rep;
    endfunction

    task automatic send_sample(input logic pin, input logic [TW-1:0] now);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {7'd0, now, pin};
        do @(posedge i_clk); while (!o_s_axis_tready);
        drive_reports.push_back(beacon_drive_response(pin, now));
        samples_sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (drive_reports.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CW-1:0] angle, input logic [CW-1:0] frac);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= bsdw_pkg::CFG_IDX_ANGLE;
        i_cfg_wdata <= angle;
        @(posedge i_clk);
        i_cfg_idx <= bsdw_pkg::CFG_IDX_FRAC;
        i_cfg_wdata <= frac;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        angle_setting = angle;
        frac_setting = frac;
    endtask

    // Rising edge at the reset pulse time gives a zero period; drive stays off at fraction zero.
    task automatic test_zero_period_and_fall();
        repeat (8) send_sample(1'b0, '0);
        repeat (8) send_sample(1'b1, '1);
        wait_drained();
    endtask

    // Out-of-range settings and a huge period give windows that wrap past the top of time.
    task automatic test_wrapping_window();
        apply_settings('1, '1);
        repeat (8) send_sample(1'b0, 32'hFFFF_FFFE);
        send_sample(1'b1, 32'h7FFF_FFFF);
        wait_drained();
    endtask

    task automatic run_rotation(input int n_items);
        int sent;
        int len;
        logic pin;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                // One revolution: a lit stretch then a dark one, with rare glitches.
                len = $urandom_range(8, 24);
                for (int k = 0; k < len; k++) begin
                    pin = ($urandom_range(0, 15) == 0);
                    clock_ms += $urandom_range(0, 3);
                    send_sample(pin, clock_ms);
                    sent++;
                end
                len = $urandom_range(8, 80);
                for (int k = 0; k < len; k++) begin
                    pin = ($urandom_range(0, 15) != 0);
                    clock_ms += $urandom_range(0, 3);
                    send_sample(pin, clock_ms);
                    sent++;
                end
            end else if ($urandom_range(0, 1) == 0) begin
                len = $urandom_range(1, 20);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        clock_ms = $urandom();
                    else
                        clock_ms += $urandom_range(0, 50);
                    send_sample(1'($urandom_range(0, 1)), clock_ms);
                    sent++;
                end
            end else begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
            end
        end
    endtask

    task automatic test_random_settings();
        logic [CW-1:0] angles [6];
        logic [CW-1:0] fracs [6];
        angles = '{9'd0, 9'd359, 9'd90, 9'd511, 9'd180, 9'($urandom_range(0, 359))};
        fracs = '{9'd256, 9'd0, 9'd128, 9'd511, 9'd1, 9'($urandom_range(1, 256))};
        for (int p = 0; p < 6; p++) begin
            apply_settings(angles[p], fracs[p]);
            run_rotation(190);
            wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (ready_run == 0) begin
            ready_run <= $urandom_range(4, 60);
            ready_choppy <= ($urandom_range(0, 2) != 0);
        end else begin
            ready_run <= ready_run - 1;
        end
        i_m_axis_tready <= ready_choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    always @(posedge i_clk) begin
        t_beacon_report got;
        t_beacon_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_beacon_report'(o_m_axis_tdata[$bits(t_beacon_report)-1:0]);
            if (drive_reports.size() == 0) begin
                $error("Unexpected result item: %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = drive_reports.pop_front();
                if (got.drive_now) drive_hits++;
                if (got.drive_now !== want.drive_now) begin
                    $error("drive_now mismatch: expected %0d, got %0d",
                           want.drive_now, got.drive_now);
                    mismatches++;
                end
                if (got.beacon_seen !== want.beacon_seen) begin
                    $error("beacon_seen mismatch: expected %0d, got %0d",
                           want.beacon_seen, got.beacon_seen);
                    mismatches++;
                end
                if (got.led_green !== want.led_green) begin
                    $error("led_green mismatch: expected %0d, got %0d",
                           want.led_green, got.led_green);
                    mismatches++;
                end
                if (got.rpm !== want.rpm) begin
                    $error("rpm mismatch: expected %0d, got %0d", want.rpm, got.rpm);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_period_and_fall();
        test_wrapping_window();
        test_random_settings();
        $display("Sent %0d samples across 8 settings, %0d rising and %0d falling beacon edges.",
                 samples_sent, rising_edges, falling_edges);
        $display("Drive output was active on %0d result items.", drive_hits);
        if (mismatches == 0 && drive_reports.size() == 0)
            $display("** beacon_synced_drive_window: PASSED **");
        else
            $display("** beacon_synced_drive_window: FAILED **");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Timeout with %0d result items outstanding.", drive_reports.size());
        $display("** beacon_synced_drive_window: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/bsdw_pkg.sv
design/bsdw_front.sv
design/bsdw_queue.sv
design/bsdw_back.sv
design/beacon_synced_drive_window.sv
tb/tb_top.sv
